// ===== rtl/core/csvfs_pkg.sv =====
package csvfs_pkg;

  localparam int unsigned PENDING_DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] CR_LAST_WS = 8'h0D;
  localparam logic [2:0] SPACE_CODE = 3'd5;

  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic CFG_DELIMITER = 1'b0;
  localparam logic CFG_TRIM      = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_QUOTE    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_FLUSH
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic accept;
    logic flush_step;
    logic last_step;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic out_free;
    logic flush_last;
    logic hold_ovf;
  } sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= TAB_BYTE) && (c <= CR_LAST_WS)) || (c == SPACE_BYTE);
  endfunction

  function automatic logic [2:0] ws_code(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - TAB_BYTE;
    return (c == SPACE_BYTE) ? SPACE_CODE : diff[2:0];
  endfunction

  function automatic logic [7:0] ws_byte(input logic [2:0] code);
    return (code == SPACE_CODE) ? SPACE_BYTE : (TAB_BYTE + {5'b0, code});
  endfunction

endpackage

// ===== rtl/core/csv_field_splitter.sv =====
// Channel  Direction  Handshake              Payload
// input    in         in_valid_i/in_ready_o  op_i, ch_i
// output   out        out_valid_o/out_ready_i out_byte_o, kind_o, error_o, last_of_run_o
// config   in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Items that yield at most one result stream at one per cycle while the output register is not stalled.
// An item that releases held bytes is taken first, then each held byte is emitted in order, and
// then the content byte; on a buffer overflow there is no content byte.
// Every result passes through the single output register, so the buffer drains one byte a cycle unless stalled.
// Input is not taken while held bytes drain or while the output register is full and stalled.
// Reset is asynchronous and active low; the whitespace buffer itself is not cleared.
module csv_field_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic [1:0] error_o,
  output logic       last_of_run_o
);

  csvfs_pkg::cmd_t cmd;
  csvfs_pkg::sts_t sts;

  csvfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csvfs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .ch_i          (ch_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .error_o       (error_o),
    .last_of_run_o (last_of_run_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== rtl/core/csvfs_ctrl.sv =====
module csvfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  csvfs_pkg::sts_t    sts_i,
  output csvfs_pkg::cmd_t    cmd_o
);

  csvfs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      csvfs_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && (sts_i.act == csvfs_pkg::ACT_FLUSH)) begin
          state_d = csvfs_pkg::ST_FLUSH;
        end
      end
      csvfs_pkg::ST_FLUSH: begin
        if (sts_i.out_free && sts_i.flush_last) begin
          state_d = sts_i.hold_ovf ? csvfs_pkg::ST_IDLE : csvfs_pkg::ST_LAST;
        end
      end
      csvfs_pkg::ST_LAST: begin
        if (sts_i.out_free) begin
          state_d = csvfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csvfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      csvfs_pkg::ST_IDLE: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
      end
      csvfs_pkg::ST_FLUSH: begin
        cmd_o.flush_step = sts_i.out_free;
      end
      csvfs_pkg::ST_LAST: begin
        cmd_o.last_step = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csvfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/csvfs_dp.sv =====
module csvfs_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            op_i,
  input  logic [7:0]      ch_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic [1:0]      error_o,
  output logic            last_of_run_o,
  input  csvfs_pkg::cmd_t cmd_i,
  output csvfs_pkg::sts_t sts_o
);

  localparam int unsigned CNT_W = csvfs_pkg::CNT_W;
  localparam int unsigned IDX_W = csvfs_pkg::IDX_W;
  localparam int unsigned DEPTH = csvfs_pkg::PENDING_DEPTH;

  logic [7:0]       delim_q;
  logic             trim_q;
  logic             in_quotes_q, quote_pend_q, raw_empty_q, started_q, stopped_q, ovf_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [2:0]       pend_q [DEPTH];
  logic [IDX_W-1:0] flush_idx_q;
  logic [7:0]       hold_ch_q;
  logic             hold_ovf_q;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  csvfs_pkg::kind_e kind_q;
  csvfs_pkg::err_e  err_q;
  logic             last_q;

  // Next line state for the item at the input, applied when it is accepted.
  logic             p_inq, p_qp, p_empty, p_started, p_stopped, p_ovf;
  logic [CNT_W-1:0] p_count;
  csvfs_pkg::act_e  p_act;
  logic             p_ovf_mode, p_wr;
  csvfs_pkg::kind_e p_kind;
  csvfs_pkg::err_e  p_err;
  logic [7:0]       p_byte;
  logic             content;
  logic [7:0]       cbyte;
  logic             inq_eff;

  logic             flush_last;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [2:0]       wr_data;
  logic             load_out;
  logic [7:0]       nb;
  csvfs_pkg::kind_e nk;
  csvfs_pkg::err_e  ne;
  logic             nl;

  always_comb begin
    p_inq      = in_quotes_q;
    p_qp       = quote_pend_q;
    p_empty    = raw_empty_q;
    p_started  = started_q;
    p_stopped  = stopped_q;
    p_ovf      = ovf_q;
    p_count    = count_q;
    p_act      = csvfs_pkg::ACT_NONE;
    p_ovf_mode = 1'b0;
    p_wr       = 1'b0;
    p_kind     = csvfs_pkg::KIND_BYTE;
    p_err      = csvfs_pkg::ERR_NONE;
    p_byte     = '0;
    content    = 1'b0;
    cbyte      = ch_i;
    inq_eff    = quote_pend_q ? 1'b0 : in_quotes_q;
    if (op_i == csvfs_pkg::OP_EOL) begin
      p_act  = csvfs_pkg::ACT_EMIT;
      p_kind = csvfs_pkg::KIND_RECORD_END;
      if (inq_eff) begin
        p_err = csvfs_pkg::ERR_QUOTE;
      end else if (ovf_q) begin
        p_err = csvfs_pkg::ERR_OVERFLOW;
      end
      p_inq     = 1'b0;
      p_qp      = 1'b0;
      p_stopped = 1'b0;
      p_ovf     = 1'b0;
      p_empty   = 1'b1;
      p_started = 1'b0;
      p_count   = '0;
    end else if (!stopped_q) begin
      if (ch_i == csvfs_pkg::NUL_BYTE) begin
        p_qp      = 1'b0;
        p_inq     = inq_eff;
        p_stopped = 1'b1;
      end else if (quote_pend_q && (ch_i == csvfs_pkg::QUOTE_BYTE)) begin
        p_qp    = 1'b0;
        content = 1'b1;
      end else begin
        p_qp  = 1'b0;
        p_inq = inq_eff;
        if (!inq_eff && raw_empty_q && (ch_i == csvfs_pkg::QUOTE_BYTE)) begin
          p_inq = 1'b1;
        end else if (inq_eff && (ch_i == csvfs_pkg::QUOTE_BYTE)) begin
          p_qp = 1'b1;
        end else if (!inq_eff && (ch_i == delim_q)) begin
          p_act     = csvfs_pkg::ACT_EMIT;
          p_kind    = csvfs_pkg::KIND_FIELD_END;
          p_empty   = 1'b1;
          p_started = 1'b0;
          p_count   = '0;
        end else if (!inq_eff && ((ch_i == csvfs_pkg::CR_BYTE) ||
                                  (ch_i == csvfs_pkg::LF_BYTE))) begin
          p_stopped = 1'b1;
        end else begin
          content = 1'b1;
        end
      end
    end
    if (content) begin
      p_empty = 1'b0;
      if (trim_q && csvfs_pkg::is_ws(cbyte)) begin
        if (started_q) begin
          if (count_q < CNT_W'(DEPTH)) begin
            p_wr    = 1'b1;
            p_count = count_q + CNT_W'(1);
          end else begin
            p_act      = csvfs_pkg::ACT_FLUSH;
            p_ovf_mode = 1'b1;
            p_ovf      = 1'b1;
          end
        end
      end else begin
        p_started = 1'b1;
        if (count_q != '0) begin
          p_act = csvfs_pkg::ACT_FLUSH;
        end else begin
          p_act  = csvfs_pkg::ACT_EMIT;
          p_kind = csvfs_pkg::KIND_BYTE;
          p_byte = cbyte;
        end
      end
    end
  end

  assign flush_last = (flush_idx_q == IDX_W'(count_q - CNT_W'(1)));

  assign sts_o.act        = p_act;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.flush_last = flush_last;
  assign sts_o.hold_ovf   = hold_ovf_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = csvfs_pkg::ws_code(ch_i);
    count_d = count_q;
    if (cmd_i.accept) begin
      wr_en   = p_wr;
      count_d = p_count;
    end else if (cmd_i.flush_step && flush_last && hold_ovf_q) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = csvfs_pkg::ws_code(hold_ch_q);
      count_d = CNT_W'(1);
    end else if (cmd_i.last_step) begin
      count_d = '0;
    end
  end

  always_comb begin
    load_out = 1'b0;
    nb       = '0;
    nk       = csvfs_pkg::KIND_BYTE;
    ne       = csvfs_pkg::ERR_NONE;
    nl       = 1'b1;
    if (cmd_i.accept && (p_act == csvfs_pkg::ACT_EMIT)) begin
      load_out = 1'b1;
      nb       = p_byte;
      nk       = p_kind;
      ne       = p_err;
    end else if (cmd_i.flush_step) begin
      load_out = 1'b1;
      nb       = csvfs_pkg::ws_byte(pend_q[flush_idx_q]);
      nl       = flush_last && hold_ovf_q;
    end else if (cmd_i.last_step) begin
      load_out = 1'b1;
      nb       = hold_ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q      <= csvfs_pkg::DELIM_RESET;
      trim_q       <= 1'b0;
      in_quotes_q  <= 1'b0;
      quote_pend_q <= 1'b0;
      raw_empty_q  <= 1'b1;
      started_q    <= 1'b0;
      stopped_q    <= 1'b0;
      ovf_q        <= 1'b0;
      count_q      <= '0;
      flush_idx_q  <= '0;
      hold_ovf_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          csvfs_pkg::CFG_DELIMITER: delim_q <= cfg_wdata_i;
          csvfs_pkg::CFG_TRIM:      trim_q  <= cfg_wdata_i[0];
          default:                  trim_q  <= trim_q;
        endcase
      end
      if (cmd_i.accept) begin
        in_quotes_q  <= p_inq;
        quote_pend_q <= p_qp;
        raw_empty_q  <= p_empty;
        started_q    <= p_started;
        stopped_q    <= p_stopped;
        ovf_q        <= p_ovf;
        flush_idx_q  <= '0;
        hold_ovf_q   <= p_ovf_mode;
      end else if (cmd_i.flush_step) begin
        flush_idx_q <= flush_idx_q + IDX_W'(1);
      end
      count_q     <= count_d;
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pend_q[wr_addr] <= wr_data;
    end
    if (cmd_i.accept) begin
      hold_ch_q <= ch_i;
    end
    if (load_out) begin
      out_byte_q <= nb;
      kind_q     <= nk;
      err_q      <= ne;
      last_q     <= nl;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign kind_o        = kind_q;
  assign error_o       = err_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Held whitespace count exceeds the buffer depth.");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush_step |-> (count_q != '0))
    else $error("Flush step with an empty whitespace buffer.");

  a_last_not_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.last_step |-> !hold_ovf_q)
    else $error("Content byte emitted after an overflow flush.");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && (op_i == csvfs_pkg::OP_EOL)) |=>
      ((count_q == '0) && !in_quotes_q && !stopped_q && !ovf_q))
    else $error("Line state not cleared after end of line.");
`endif

endmodule

// ===== dv/csv_field_splitter_tb.sv =====
`timescale 1ns / 100ps

module csv_field_splitter_tb;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 140;
  localparam int unsigned PHASE_ITEMS = 24;

  typedef struct {
    logic [7:0]            data;
    csvfs_pkg::kind_e      kind;
    csvfs_pkg::err_e       err;
    logic                  last;
  } csv_result_t;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  class csv_scoreboard;
    logic [7:0]  delim;
    logic        trim_on;
    logic        in_quotes;
    logic        quote_pending;
    logic        raw_empty;
    logic        field_started;
    logic        line_stopped;
    logic        overflow_seen;
    logic [2:0]  held_ws [csvfs_pkg::PENDING_DEPTH];
    int unsigned held_count;
    csv_result_t step_q[$];
    csv_result_t expected_q[$];
    int unsigned mismatches;

    function new();
      delim = csvfs_pkg::DELIM_RESET;
      trim_on = 1'b0;
      in_quotes = 1'b0;
      quote_pending = 1'b0;
      line_stopped = 1'b0;
      overflow_seen = 1'b0;
      mismatches = 0;
      end_field();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("[%0t] %s", $realtime, msg);
      mismatches++;
    endtask

    function bit is_space(logic [7:0] c);
      return ((c >= csvfs_pkg::TAB_BYTE) && (c <= csvfs_pkg::CR_BYTE)) ||
             (c == csvfs_pkg::SPACE_BYTE);
    endfunction

    function void add(logic [7:0] data, csvfs_pkg::kind_e kind, csvfs_pkg::err_e err);
      csv_result_t r;
      r.data = data;
      r.kind = kind;
      r.err = err;
      r.last = 1'b0;
      step_q.insert(step_q.size(), r);
    endfunction

    function void release_held();
      for (int i = 0; i < held_count; i++) begin
        add((held_ws[i] == csvfs_pkg::SPACE_CODE) ? csvfs_pkg::SPACE_BYTE
                                                  : csvfs_pkg::TAB_BYTE + {5'b0, held_ws[i]},
            csvfs_pkg::KIND_BYTE, csvfs_pkg::ERR_NONE);
      end
      held_count = 0;
    endfunction

    function void end_field();
      raw_empty = 1'b1;
      field_started = 1'b0;
      held_count = 0;
    endfunction

    function void take_content(logic [7:0] c);
      logic [7:0] offset;
      offset = c - csvfs_pkg::TAB_BYTE;
      raw_empty = 1'b0;
      if (trim_on && is_space(c)) begin
        if (!field_started) return;
        if (held_count >= csvfs_pkg::PENDING_DEPTH) begin
          release_held();
          overflow_seen = 1'b1;
        end
        held_ws[held_count] = (c == csvfs_pkg::SPACE_BYTE) ? csvfs_pkg::SPACE_CODE
                                                           : offset[2:0];
        held_count++;
        return;
      end
      release_held();
      add(c, csvfs_pkg::KIND_BYTE, csvfs_pkg::ERR_NONE);
      field_started = 1'b1;
    endfunction

    function void note_input(logic op, logic [7:0] ch);
      csvfs_pkg::err_e err;
      step_q.delete();
      if (op == csvfs_pkg::OP_EOL) begin
        if (quote_pending) begin
          quote_pending = 1'b0;
          in_quotes = 1'b0;
        end
        err = in_quotes ? csvfs_pkg::ERR_QUOTE
                        : (overflow_seen ? csvfs_pkg::ERR_OVERFLOW : csvfs_pkg::ERR_NONE);
        add(8'h00, csvfs_pkg::KIND_RECORD_END, err);
        in_quotes = 1'b0;
        line_stopped = 1'b0;
        overflow_seen = 1'b0;
        end_field();
      end else if (!line_stopped) begin
        if (ch == csvfs_pkg::NUL_BYTE) begin
          if (quote_pending) begin
            quote_pending = 1'b0;
            in_quotes = 1'b0;
          end
          line_stopped = 1'b1;
        end else if (quote_pending && ch == csvfs_pkg::QUOTE_BYTE) begin
          quote_pending = 1'b0;
          take_content(csvfs_pkg::QUOTE_BYTE);
        end else begin
          if (quote_pending) begin
            quote_pending = 1'b0;
            in_quotes = 1'b0;
          end
          if (!in_quotes && raw_empty && ch == csvfs_pkg::QUOTE_BYTE) begin
            in_quotes = 1'b1;
          end else if (in_quotes && ch == csvfs_pkg::QUOTE_BYTE) begin
            quote_pending = 1'b1;
          end else if (!in_quotes && ch == delim) begin
            add(8'h00, csvfs_pkg::KIND_FIELD_END, csvfs_pkg::ERR_NONE);
            end_field();
          end else if (!in_quotes && (ch == csvfs_pkg::CR_BYTE ||
                                      ch == csvfs_pkg::LF_BYTE)) begin
            line_stopped = 1'b1;
          end else begin
            take_content(ch);
          end
        end
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    endfunction

    task check_result(logic [7:0] data, logic [1:0] kind, logic [1:0] err, logic last);
      csv_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: byte %02h kind %0d", data, kind));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte %02h, expected %02h", data, want.data));
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (err !== want.err)
        report($sformatf("error %0d, expected %0d", err, want.err));
      if (last !== want.last)
        report($sformatf("last_of_run %0d, expected %0d", last, want.last));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       op_i;
  logic [7:0] ch_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [1:0] error_o;
  logic       last_of_run_o;

  csv_scoreboard sb = new();
  logic [7:0]    cur_delim = csvfs_pkg::DELIM_RESET;
  int unsigned   burst_left = 0;
  int unsigned   rx_count = 0;
  rx_mode_e      rx_mode = RX_OPEN;

  csv_field_splitter u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rx_count % 48 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    rx_count++;
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= rx_count[2];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(op_i, ch_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(out_byte_o, kind_o, error_o, last_of_run_o);
    end
  end

  task automatic send_item(logic op, logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i <= op;
    ch_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [7:0] delim, logic trim);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= csvfs_pkg::CFG_DELIMITER;
    cfg_wdata_i <= delim;
    @(posedge clk_i);
    sb.delim = delim;
    cur_delim = delim;
    cfg_idx_i <= csvfs_pkg::CFG_TRIM;
    cfg_wdata_i <= {7'b0, trim};
    @(posedge clk_i);
    sb.trim_on = trim;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_ws(bit allow_stop);
    logic [7:0] c;
    do c = ($urandom_range(0, 2) == 0) ? csvfs_pkg::SPACE_BYTE : 8'($urandom_range(9, 13));
    while (!allow_stop && (c == csvfs_pkg::CR_BYTE || c == csvfs_pkg::LF_BYTE));
    return c;
  endfunction

  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    do c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                        : 8'($urandom_range(33, 126));
    while (c == csvfs_pkg::QUOTE_BYTE || c == cur_delim);
    return c;
  endfunction

  // Mostly well-formed records with random content; some carry stray bytes,
  // open quotes or an early line stop followed by junk.
  task automatic random_line(output int unsigned n_items);
    logic [7:0]  line_q[$];
    int unsigned nf;
    int unsigned run;
    logic [7:0]  stop;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) line_q.insert(line_q.size(), pick_ws(0));
      if ($urandom_range(0, 2) == 0) begin
        line_q.insert(line_q.size(), csvfs_pkg::QUOTE_BYTE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: begin
              line_q.insert(line_q.size(), csvfs_pkg::QUOTE_BYTE);
              line_q.insert(line_q.size(), csvfs_pkg::QUOTE_BYTE);
            end
            1: line_q.insert(line_q.size(), cur_delim);
            2: line_q.insert(line_q.size(), pick_ws(1));
            default: line_q.insert(line_q.size(), pick_text());
          endcase
        end
        if ($urandom_range(0, 7) != 0) line_q.insert(line_q.size(), csvfs_pkg::QUOTE_BYTE);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) line_q.insert(line_q.size(), pick_ws(0));
      end else begin
        repeat ($urandom_range(0, 5)) line_q.insert(line_q.size(), pick_text());
        if ($urandom_range(0, 2) == 0) begin
          run = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
          repeat (run) line_q.insert(line_q.size(), pick_ws(0));
          if ($urandom_range(0, 1) == 0) line_q.insert(line_q.size(), pick_text());
        end
      end
      if (f + 1 < nf) line_q.insert(line_q.size(), cur_delim);
    end
    if ($urandom_range(0, 7) == 0 && line_q.size() > 0)
      line_q.insert($urandom_range(0, line_q.size() - 1), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: stop = csvfs_pkg::CR_BYTE;
        1: stop = csvfs_pkg::LF_BYTE;
        default: stop = csvfs_pkg::NUL_BYTE;
      endcase
      line_q.insert(line_q.size(), stop);
      repeat ($urandom_range(1, 3)) line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
    end
    foreach (line_q[i]) send_item(csvfs_pkg::OP_BYTE, line_q[i]);
    send_item(csvfs_pkg::OP_EOL, 8'($urandom_range(0, 255)));
    n_items = line_q.size() + 1;
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned n;
    int unsigned phase;
    logic [7:0]  delim;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= csvfs_pkg::CFG_DELIMITER;
    cfg_wdata_i <= 8'h00;
    in_valid_i <= 1'b0;
    op_i <= csvfs_pkg::OP_BYTE;
    ch_i <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Quoted field with a doubled quote, then a field end.
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, "a");
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, "b");
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::DELIM_RESET);
    // A stopped line ignores everything until the end of line.
    send_item(csvfs_pkg::OP_BYTE, 8'hFF);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::CR_BYTE);
    send_item(csvfs_pkg::OP_BYTE, "z");
    send_item(csvfs_pkg::OP_EOL, 8'hFF);
    // Closing quote still pending when NUL arrives, then at end of line.
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::NUL_BYTE);
    send_item(csvfs_pkg::OP_EOL, 8'h00);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_EOL, 8'h00);
    // Quote never closed.
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::QUOTE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, "k");
    send_item(csvfs_pkg::OP_EOL, 8'h00);
    settle();

    // Trailing whitespace is held, then trimming is turned off mid-field.
    write_config(csvfs_pkg::DELIM_RESET, 1'b1);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::SPACE_BYTE);
    send_item(csvfs_pkg::OP_BYTE, "c");
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::TAB_BYTE);
    send_item(csvfs_pkg::OP_BYTE, csvfs_pkg::SPACE_BYTE);
    settle();
    write_config(csvfs_pkg::DELIM_RESET, 1'b0);
    send_item(csvfs_pkg::OP_BYTE, "d");
    send_item(csvfs_pkg::OP_EOL, 8'h00);
    settle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 7)
        0: delim = csvfs_pkg::DELIM_RESET;
        1: delim = 8'h00;
        2: delim = 8'hFF;
        3: delim = csvfs_pkg::TAB_BYTE;
        4: delim = csvfs_pkg::QUOTE_BYTE;
        5: delim = 8'h3B;
        default: delim = 8'($urandom_range(0, 255));
      endcase
      write_config(delim, (phase % 2) == 0);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        random_line(n);
        phase_sent += n;
      end
      sent += phase_sent;
      settle();
      phase++;
    end

    settle();
    while (sb.expected_q.size() != 0) begin
      void'(sb.expected_q.pop_front());
      sb.report("expected result never arrived");
    end
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
